>>> design/fftr2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fftr2_pkg
// Shared types, saturation helpers and the twiddle generator for the framed
// radix-2 FFT.
// ----------------------------------------------------------------------------
package fftr2_pkg;

  // controller -> datapath commands
  typedef struct packed {
    logic rd_en;      // capture both work read ports and the twiddle
    logic mul_en;     // capture the four twiddle products
    logic add_en;     // capture the butterfly sums
    logic wr_sample;  // write an incoming sample into work memory
    logic wr_upper;   // write the upper butterfly output
    logic wr_lower;   // write the lower butterfly output
    logic copy_wr;    // write a saturated work entry into the spectrum
    logic emit;       // load the output register
    logic last;       // bin being emitted closes the spectrum
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic out_busy;   // output register holds a transaction not yet taken
  } sts_t;

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] ONE_Q30    = 64'd1073741824;

  // Taylor term divisors, (2n)(2n+1) for sine and (2n-1)(2n) for cosine
  localparam int SIN_DIV [10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};
  localparam int COS_DIV [10] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380};

  localparam logic signed [27:0] MAX25 = 28'sd16777215;
  localparam logic signed [27:0] MIN25 = -28'sd16777216;
  localparam logic signed [24:0] MAX24 = 25'sd8388607;
  localparam logic signed [24:0] MIN24 = -25'sd8388608;

  function automatic logic signed [24:0] sat25(input logic signed [27:0] v);
    logic signed [24:0] r;
    if (v > MAX25) r = 25'sd16777215;
    else if (v < MIN25) r = -25'sd16777216;
    else r = v[24:0];
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    logic signed [23:0] r;
    if (v > MAX24) r = 24'sd8388607;
    else if (v < MIN24) r = -24'sd8388608;
    else r = v[23:0];
    return r;
  endfunction

  // Q2.30 to Q1.15, clipped to 0..32767
  function automatic logic [15:0] q30_to_q15(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v < 0) ? 64'sd0 : v;
    t = (t + 64'sd16384) >>> 15;
    if (t > 64'sd32767) t = 64'sd32767;
    return t[15:0];
  endfunction

  // {cos, sin} of 2*pi*a/2^stages for a in the first quadrant
  function automatic logic [31:0] quarter_wave(input int stages, input int a);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] ts;
    logic [63:0] tc;
    logic signed [63:0] ss;
    logic signed [63:0] cs;
    x  = (64'(a) * TWO_PI_Q30 + (64'd1 << (stages - 1))) >> stages;
    x2 = (x * x) >> 30;
    ts = x;
    tc = ONE_Q30;
    ss = $signed(x);
    cs = $signed(ONE_Q30);
    for (int n = 0; n < 10; n++) begin
      ts = ((ts * x2) >> 30) / 64'(SIN_DIV[n]);
      tc = ((tc * x2) >> 30) / 64'(COS_DIV[n]);
      if ((n % 2) == 0) begin
        ss = ss - $signed(ts);
        cs = cs - $signed(tc);
      end else begin
        ss = ss + $signed(ts);
        cs = cs + $signed(tc);
      end
    end
    return {q30_to_q15(cs), q30_to_q15(ss)};
  endfunction

  // {cos, sin} twiddle entry k of a 2^stages point transform, k < 2^(stages-1)
  function automatic logic [31:0] tw_pair(input int stages, input int k);
    logic [31:0] w;
    logic [31:0] r;
    int q;
    q = 1 << (stages - 2);
    if (k <= q) begin
      r = quarter_wave(stages, k);
    end else begin
      w = quarter_wave(stages, k - q);
      r = {16'(-w[15:0]), w[31:16]};
    end
    return r;
  endfunction

endpackage

>>> design/fftr2_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fftr2_ctrl
// Sequencer: sample collection, butterfly schedule, spectrum copy, and all
// memory addresses.
// ----------------------------------------------------------------------------
module fftr2_ctrl
  import fftr2_pkg::*;
#(
  parameter int POINTS = 256,
  parameter int STAGES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  sts_t                sts,
  output cmd_t                cmd,
  output logic [STAGES-1:0]   rd_addr_a,
  output logic [STAGES-1:0]   rd_addr_b,
  output logic [STAGES-2:0]   tw_addr,
  output logic [STAGES-1:0]   wr_addr,
  output logic [STAGES-1:0]   spec_rd_addr,
  output logic [STAGES-1:0]   spec_wr_addr
);

  localparam int SW = $clog2(STAGES);

  typedef enum logic [2:0] {
    S_COLLECT, S_BF_RD, S_BF_MUL, S_BF_ADD, S_BF_WRU, S_BF_WRL, S_COPY
  } state_t;

  state_t            state;
  logic [STAGES-1:0] fill;
  logic              ready;
  logic              pf_valid;
  logic [SW-1:0]     stg;
  logic [STAGES-2:0] bfly;
  logic [STAGES:0]   cnt;

  logic              accept;
  logic [STAGES-1:0] bpad;
  logic [STAGES-1:0] mask;
  logic [STAGES-1:0] up_idx;
  logic [STAGES-1:0] lo_idx;
  logic [STAGES-1:0] rev;

  // input handshake
  assign s_tready = (state == S_COLLECT) && pf_valid && !(ready && sts.out_busy);
  assign accept   = s_tvalid && s_tready;

  // butterfly pair: insert a zero (upper) or one (lower) at bit stg
  always_comb begin
    bpad   = {1'b0, bfly};
    mask   = (STAGES'(1) << stg) - STAGES'(1);
    up_idx = (bpad & mask) | ((bpad & ~mask) << 1);
    lo_idx = up_idx | (STAGES'(1) << stg);
    for (int k = 0; k < STAGES; k++) begin
      rev[k] = fill[STAGES-1-k];
    end
  end

  // addresses
  assign tw_addr      = bfly << (SW'(STAGES - 1) - stg);
  assign rd_addr_a    = (state == S_COPY) ? cnt[STAGES-1:0] : up_idx;
  assign rd_addr_b    = lo_idx;
  assign spec_rd_addr = fill;
  assign spec_wr_addr = cnt[STAGES-1:0] - STAGES'(1);

  always_comb begin
    unique case (state)
      S_COLLECT: wr_addr = rev;
      S_BF_WRU:  wr_addr = up_idx;
      default:   wr_addr = lo_idx;
    endcase
  end

  // commands
  always_comb begin
    cmd           = '0;
    cmd.rd_en     = (state == S_BF_RD) || (state == S_COPY);
    cmd.mul_en    = (state == S_BF_MUL);
    cmd.add_en    = (state == S_BF_ADD);
    cmd.wr_upper  = (state == S_BF_WRU);
    cmd.wr_lower  = (state == S_BF_WRL);
    cmd.copy_wr   = (state == S_COPY) && (cnt != '0);
    cmd.wr_sample = accept;
    cmd.emit      = accept && ready;
    cmd.last      = (fill == STAGES'(POINTS - 1));
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_COLLECT;
      fill     <= '0;
      ready    <= 1'b0;
      pf_valid <= 1'b0;
      stg      <= '0;
      bfly     <= '0;
      cnt      <= '0;
    end else begin
      // spectrum read data is good in the cycle after its address settles
      pf_valid <= (state == S_COLLECT) && !accept;
      unique case (state)
        S_COLLECT: begin
          if (accept) begin
            fill <= fill + STAGES'(1);
            if (fill == STAGES'(POINTS - 1)) begin
              state <= S_BF_RD;
              stg   <= '0;
              bfly  <= '0;
            end
          end
        end
        S_BF_RD:  state <= S_BF_MUL;
        S_BF_MUL: state <= S_BF_ADD;
        S_BF_ADD: state <= S_BF_WRU;
        S_BF_WRU: state <= S_BF_WRL;
        S_BF_WRL: begin
          bfly <= bfly + (STAGES-1)'(1);
          if (bfly == '1) begin
            if (stg == SW'(STAGES - 1)) begin
              state <= S_COPY;
              cnt   <= '0;
            end else begin
              stg   <= stg + SW'(1);
              state <= S_BF_RD;
            end
          end else begin
            state <= S_BF_RD;
          end
        end
        S_COPY: begin
          cnt <= cnt + (STAGES+1)'(1);
          if (cnt == (STAGES+1)'(POINTS)) begin
            state <= S_COLLECT;
            ready <= 1'b1;
          end
        end
        default: state <= S_COLLECT;
      endcase
    end
  end

endmodule

>>> design/fftr2_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fftr2_dpath
// Work and spectrum memories, twiddle ROM, butterfly unit and output register.
// ----------------------------------------------------------------------------
module fftr2_dpath
  import fftr2_pkg::*;
#(
  parameter int POINTS = 256,
  parameter int STAGES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [STAGES-1:0]   rd_addr_a,
  input  logic [STAGES-1:0]   rd_addr_b,
  input  logic [STAGES-2:0]   tw_addr,
  input  logic [STAGES-1:0]   wr_addr,
  input  logic [STAGES-1:0]   spec_rd_addr,
  input  logic [STAGES-1:0]   spec_wr_addr,
  input  logic [15:0]         sample,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [55:0]         m_tdata,
  output logic                m_tlast
);

  // memories
  logic signed [24:0] work_re [POINTS];
  logic signed [24:0] work_im [POINTS];
  logic signed [23:0] spec_re [POINTS];
  logic signed [23:0] spec_im [POINTS];

  // twiddle table
  logic signed [15:0] rom_c [POINTS/2];
  logic signed [15:0] rom_s [POINTS/2];

  for (genvar k = 0; k < POINTS/2; k++) begin : g_rom
    localparam logic [31:0] TW = tw_pair(STAGES, k);
    assign rom_c[k] = TW[31:16];
    assign rom_s[k] = TW[15:0];
  end

  logic signed [24:0] a_re, a_im, b_re, b_im;
  logic signed [15:0] tw_c, tw_s;
  logic signed [40:0] p_rc, p_is, p_ic, p_rs;
  logic signed [41:0] t_re_sum, t_im_sum;
  logic signed [26:0] t_re, t_im;
  logic signed [27:0] u_re_sum, u_im_sum, l_re_sum, l_im_sum;
  logic signed [24:0] up_re, up_im, lo_re, lo_im;
  logic signed [23:0] sp_re, sp_im;
  logic [STAGES+7:0]  bin_ext;

  // work memory read ports and twiddle fetch
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      a_re <= work_re[rd_addr_a];
      a_im <= work_im[rd_addr_a];
      b_re <= work_re[rd_addr_b];
      b_im <= work_im[rd_addr_b];
      tw_c <= rom_c[tw_addr];
      tw_s <= rom_s[tw_addr];
    end
  end

  // twiddle products on the lower input
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_rc <= b_re * tw_c;
      p_is <= b_im * tw_s;
      p_ic <= b_im * tw_c;
      p_rs <= b_re * tw_s;
    end
  end

  // round half up, then add/subtract with 25-bit saturation
  always_comb begin
    t_re_sum = 42'(p_rc) + 42'(p_is) + 42'sd16384;
    t_im_sum = 42'(p_ic) - 42'(p_rs) + 42'sd16384;
    t_re     = t_re_sum[41:15];
    t_im     = t_im_sum[41:15];
    u_re_sum = 28'(a_re) + 28'(t_re);
    u_im_sum = 28'(a_im) + 28'(t_im);
    l_re_sum = 28'(a_re) - 28'(t_re);
    l_im_sum = 28'(a_im) - 28'(t_im);
  end

  always_ff @(posedge clk) begin
    if (cmd.add_en) begin
      up_re <= sat25(u_re_sum);
      up_im <= sat25(u_im_sum);
      lo_re <= sat25(l_re_sum);
      lo_im <= sat25(l_im_sum);
    end
  end

  // work memory write port
  always_ff @(posedge clk) begin
    if (cmd.wr_sample) begin
      work_re[wr_addr] <= 25'($signed(sample));
      work_im[wr_addr] <= '0;
    end else if (cmd.wr_upper) begin
      work_re[wr_addr] <= up_re;
      work_im[wr_addr] <= up_im;
    end else if (cmd.wr_lower) begin
      work_re[wr_addr] <= lo_re;
      work_im[wr_addr] <= lo_im;
    end
  end

  // spectrum memory: copy write, prefetch read
  always_ff @(posedge clk) begin
    if (cmd.copy_wr) begin
      spec_re[spec_wr_addr] <= sat24(a_re);
      spec_im[spec_wr_addr] <= sat24(a_im);
    end
    sp_re <= spec_re[spec_rd_addr];
    sp_im <= spec_im[spec_rd_addr];
  end

  // output register
  assign bin_ext     = {8'b0, spec_rd_addr};
  assign sts.out_busy = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {bin_ext[7:0], sp_im, sp_re};
      m_tlast <= cmd.last;
    end
  end

endmodule

>>> design/fft_radix2_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fft_radix2_frame
// Framed radix-2 DIT FFT of real 16-bit samples; each sample of a frame
// returns one bin of the previous frame's spectrum.
//
//   Channel  Dir  Width  Content
//   s_*      in   16     sample
//   m_*      out  56+1   bin_real, bin_imag, bin_number; tlast = frame_last
//
// Collecting: no new sample is taken until the spectrum prefetch is good.
// After the last sample of a frame the input stalls while one shared butterfly
// steps through read, multiply, add, write upper and write lower on a single
// work write port for every pair and stage, then while the spectrum is copied.
// Reset clears control only; the first frame returns no transactions.
// A stalled output holds the input off while a spectrum is being returned.
// ----------------------------------------------------------------------------
module fft_radix2_frame
  import fftr2_pkg::*;
#(
  parameter int POINTS = 256,
  parameter int STAGES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [23:0] bin_real, [47:24] bin_imag, [55:48] bin_number
  output logic        m_tlast    // frame_last
);

  cmd_t              cmd;
  sts_t              sts;
  logic [STAGES-1:0] rd_addr_a;
  logic [STAGES-1:0] rd_addr_b;
  logic [STAGES-2:0] tw_addr;
  logic [STAGES-1:0] wr_addr;
  logic [STAGES-1:0] spec_rd_addr;
  logic [STAGES-1:0] spec_wr_addr;

  fftr2_ctrl #(
    .POINTS (POINTS),
    .STAGES (STAGES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .sts          (sts),
    .cmd          (cmd),
    .rd_addr_a    (rd_addr_a),
    .rd_addr_b    (rd_addr_b),
    .tw_addr      (tw_addr),
    .wr_addr      (wr_addr),
    .spec_rd_addr (spec_rd_addr),
    .spec_wr_addr (spec_wr_addr)
  );

  fftr2_dpath #(
    .POINTS (POINTS),
    .STAGES (STAGES)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .rd_addr_a    (rd_addr_a),
    .rd_addr_b    (rd_addr_b),
    .tw_addr      (tw_addr),
    .wr_addr      (wr_addr),
    .spec_rd_addr (spec_rd_addr),
    .spec_wr_addr (spec_wr_addr),
    .sample       (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast)
  );

endmodule

>>> tb/sv/fft_radix2_frame_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fft_radix2_frame_tb
// Self-checking bench for the framed radix-2 FFT. Samples stream in frame
// after frame. A local fixed-point FFT predicts each returned bin, and every
// output transaction is checked field by field against the oldest prediction.
// Both sides idle at random, with short and long gaps.
// ----------------------------------------------------------------------------
module fft_radix2_frame_tb;

  localparam int NPT     = 256;
  localparam int NSTG    = 8;
  localparam int WD_MAX  = 30000;
  localparam longint unsigned TWOPI_Q30 = 64'd6746518852;
  localparam longint unsigned UNIT_Q30  = 64'd1073741824;

  typedef struct packed {
    logic [23:0] re;
    logic [23:0] im;
    logic [7:0]  bin;
    logic        last;
  } bin_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [15:0] sample
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // [23:0] bin_real, [47:24] bin_imag, [55:48] bin_number
  logic        m_tlast;        // frame_last

  fft_radix2_frame u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // predictor state
  longint frame_re [NPT];
  longint frame_im [NPT];
  longint spec_re  [NPT];
  longint spec_im  [NPT];
  longint tw_cos   [NPT/2];
  longint tw_sin   [NPT/2];
  int     fill_pos;
  bit     have_spectrum;

  logic [15:0] sample_q[$];
  bin_t        bins_due[$];
  int          errors;
  int          bins_seen;
  int          frames_done;
  int          in_gap;
  int          out_gap;
  int          idle_cycles;
  int          in_count;

  function automatic longint clip(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint to_q15(longint v);
    if (v < 0) v = 0;
    v = (v + 16384) >>> 15;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  // Taylor sine/cosine in Q2.30 for angle 2*pi*a/NPT, first quadrant, returned as Q1.15
  task automatic quadrant_point(input int a, output longint c, output longint s);
    longint unsigned x, x2, ts, tc;
    longint ss, cs;
    x  = (longint'(a) * TWOPI_Q30 + NPT / 2) / NPT;
    x2 = (x * x) >> 30;
    ts = x;
    tc = UNIT_Q30;
    ss = x;
    cs = UNIT_Q30;
    for (int n = 1; n <= 10; n++) begin
      ts = ((ts * x2) >> 30) / ((2 * n) * (2 * n + 1));
      tc = ((tc * x2) >> 30) / ((2 * n - 1) * (2 * n));
      if (n % 2) begin
        ss -= longint'(ts); cs -= longint'(tc);
      end else begin
        ss += longint'(ts); cs += longint'(tc);
      end
    end
    c = to_q15(cs);
    s = to_q15(ss);
  endtask

  task automatic build_twiddles();
    longint c, s;
    for (int k = 0; k < NPT / 2; k++) begin
      if (k <= NPT / 4) begin
        quadrant_point(k, c, s);
        tw_cos[k] = c; tw_sin[k] = s;
      end else begin
        quadrant_point(k - NPT / 4, c, s);
        tw_cos[k] = -s; tw_sin[k] = c;
      end
    end
  endtask

  // bit reversal then in-place DIT butterflies, rounding each summed twiddle product
  task automatic run_fft();
    int j, ip, span, half, ti;
    longint t, c, s, xr, xi, tr, tim, ar, ai;
    for (int i = 0; i < NPT; i++) begin
      j = 0;
      for (int k = 0; k < NSTG; k++) if (i & (1 << k)) j |= 1 << (NSTG - 1 - k);
      if (i < j) begin
        t = frame_re[i]; frame_re[i] = frame_re[j]; frame_re[j] = t;
        t = frame_im[i]; frame_im[i] = frame_im[j]; frame_im[j] = t;
      end
    end
    for (int stg = 1; stg <= NSTG; stg++) begin
      span = 1 << stg;
      half = span >> 1;
      for (int b = 0; b < half; b++) begin
        ti = (b << (NSTG - stg)) & (NPT / 2 - 1);
        c = tw_cos[ti];
        s = tw_sin[ti];
        for (int i = b; i + half < NPT; i += span) begin
          ip = i + half;
          xr = frame_re[ip]; xi = frame_im[ip];
          tr  = (xr * c + xi * s + 16384) >>> 15;
          tim = (xi * c - xr * s + 16384) >>> 15;
          ar = frame_re[i]; ai = frame_im[i];
          frame_re[ip] = clip(ar - tr, 25);
          frame_im[ip] = clip(ai - tim, 25);
          frame_re[i]  = clip(ar + tr, 25);
          frame_im[i]  = clip(ai + tim, 25);
        end
      end
    end
  endtask

  task automatic predict_bin(input logic [15:0] smp);
    bin_t b;
    if (have_spectrum) begin
      b.re   = 24'(spec_re[fill_pos]);
      b.im   = 24'(spec_im[fill_pos]);
      b.bin  = 8'(fill_pos);
      b.last = (fill_pos == NPT - 1);
      bins_due.push_back(b);
    end
    frame_re[fill_pos] = longint'($signed(smp));
    frame_im[fill_pos] = 0;
    fill_pos++;
    if (fill_pos == NPT) begin
      run_fft();
      for (int i = 0; i < NPT; i++) begin
        spec_re[i] = clip(frame_re[i], 24);
        spec_im[i] = clip(frame_im[i], 24);
      end
      have_spectrum = 1'b1;
      frames_done++;
      fill_pos = 0;
    end
  endtask

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(int cnt);
    int r;
    if ((cnt / 150) % 3 == 2) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // acceptance, prediction and checking at the rising edge
  always @(posedge clk) begin
    bin_t due;
    bin_t got;
    if (!rst) begin
      idle_cycles++;
      if (s_tvalid && s_tready) begin
        predict_bin(s_tdata);
        void'(sample_q.pop_front());
        in_count++;
        in_gap = pick_gap(in_count);
        idle_cycles = 0;
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata[23:0], m_tdata[47:24], m_tdata[55:48], m_tlast};
        idle_cycles = 0;
        bins_seen++;
        if (bins_due.size() == 0) begin
          $display("%0t: unexpected output transaction, actual %h", $time, got);
          errors++;
        end else begin
          due = bins_due.pop_front();
          if (got.re !== due.re) begin
            $display("%0t: bin_real expected %h actual %h", $time, due.re, got.re);
            errors++;
          end
          if (got.im !== due.im) begin
            $display("%0t: bin_imag expected %h actual %h", $time, due.im, got.im);
            errors++;
          end
          if (got.bin !== due.bin) begin
            $display("%0t: bin_number expected %0d actual %0d", $time, due.bin, got.bin);
            errors++;
          end
          if (got.last !== due.last) begin
            $display("%0t: frame_last expected %b actual %b", $time, due.last, got.last);
            errors++;
          end
        end
      end
      if (idle_cycles >= WD_MAX) begin
        $display("%0t: watchdog expired, %0d bins outstanding", $time, bins_due.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // sample driver, falling edge
  always @(negedge clk) begin
    if (rst || sample_q.size() == 0) begin
      s_tvalid <= 1'b0;
    end else if (in_gap > 0) begin
      s_tvalid <= 1'b0;
      in_gap--;
    end else begin
      s_tvalid <= 1'b1;
      s_tdata  <= sample_q[0];
    end
  end

  // output backpressure, falling edge
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (out_gap > 0) begin
      m_tready <= 1'b0;
      out_gap--;
    end else begin
      m_tready <= 1'b1;
      out_gap = pick_gap(bins_seen + 75);
    end
  end

  initial begin
    logic [15:0] edges [8];
    errors = 0; bins_seen = 0; frames_done = 0; in_gap = 0; out_gap = 0;
    idle_cycles = 0; in_count = 0; fill_pos = 0; have_spectrum = 1'b0;
    build_twiddles();
    edges = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA, 16'h4000};

    // frame 0: extremes up front, then random content
    for (int i = 0; i < 24; i++) sample_q.push_back(edges[i % 8]);
    for (int i = 24; i < NPT; i++) sample_q.push_back(16'($urandom));
    // frame 1: full-scale negative DC, largest bin magnitude
    for (int i = 0; i < NPT; i++) sample_q.push_back(16'h8000);
    // part of frame 2: random, mix of full range and small values; these
    // samples return most of the frame 1 spectrum
    for (int i = 0; i < NPT - 68; i++) begin
      if ($urandom_range(3) == 0) sample_q.push_back(16'($signed($urandom_range(64)) - 32));
      else sample_q.push_back(16'($urandom));
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (sample_q.size() == 0 && bins_due.size() == 0);
    repeat (200) @(posedge clk);
    $display("Streamed %0d samples over %0d full frames; %0d spectrum bins checked.",
             in_count, frames_done, bins_seen);
    if (errors == 0 && bins_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
design/fftr2_pkg.sv
design/fftr2_ctrl.sv
design/fftr2_dpath.sv
design/fft_radix2_frame.sv
tb/sv/fft_radix2_frame_tb.sv
